/* rtl/core/packed_bitfield_store_assert.svh */
// Assertion macros used by the checker file.
`ifndef PACKED_BITFIELD_STORE_ASSERT_SVH
`define PACKED_BITFIELD_STORE_ASSERT_SVH

// Property checked at every rising clock edge, ignored while rst is high.
`define PBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define PBS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/pbs_pkg.sv */
package pbs_pkg;

  localparam int WORD_W  = 16;
  localparam int PAIR_W  = 32;
  localparam int OFF_W   = 4;
  localparam int WIU_W   = 7;

  // request kinds
  localparam logic [1:0] KIND_FIELD_READ  = 2'd0;
  localparam logic [1:0] KIND_FIELD_WRITE = 2'd1;
  localparam logic [1:0] KIND_WORD_READ   = 2'd2;
  localparam logic [1:0] KIND_WORD_WRITE  = 2'd3;

  // register index of words_in_use (paddr[2])
  localparam logic REG_WORDS_IN_USE = 1'b0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  bit_position;
    logic [4:0]  field_width;
    logic [5:0]  word_index;
    logic [15:0] write_value;
  } in_req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        range_error;
  } out_rsp_t;

endpackage

/* rtl/core/pbs_ram.sv */
module pbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/packed_bitfield_store.sv */
// packed_bitfield_store: a bit string of NUM_WORDS 16-bit words, packed MSB
// first (bit 0 is the MSB of word 0). Each request is a field read, field
// write (1 to 16 bits at any bit position, possibly straddling two words),
// word read or word write. Anything reaching past min(words_in_use,
// NUM_WORDS) returns range_error: writes are dropped, reads give zero.
// Rate: one request per cycle sustained while out_ready is high; a request
// passes the s_* request stage, then the result register. Storage is split
// into an even-word bank and an odd-word bank, so both words of a straddling
// field are read and written in the same cycle; back-to-back read-modify-
// writes are covered by a one-entry write bypass per bank. After reset a
// clearing pass zeroes the store with in_ready low; configuration writes
// are accepted throughout. Config: words_in_use at byte address 0.
module packed_bitfield_store #(
  parameter int NUM_WORDS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pbs_pkg::in_req_t in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output pbs_pkg::out_rsp_t out_rsp,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int BANK_DEPTH = (NUM_WORDS + 1) / 2;
  localparam int RW         = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;

  // ---------------- configuration ----------------
  logic [pbs_pkg::WIU_W-1:0] words_in_use;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= pbs_pkg::WIU_W'(64);
    end else if (psel && penable && pwrite && paddr[2] == pbs_pkg::REG_WORDS_IN_USE) begin
      words_in_use <= pwdata[pbs_pkg::WIU_W-1:0];
    end
  end

  assign prdata = (paddr[2] == pbs_pkg::REG_WORDS_IN_USE) ?
                  {{(32 - pbs_pkg::WIU_W){1'b0}}, words_in_use} : 32'd0;

  // ---------------- clearing pass ----------------
  logic          clearing;
  logic [RW-1:0] clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + RW'(1);
      if (clr_row == RW'(BANK_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------- request stage ----------------
  // s_* holds the accepted request while the banks return its words.
  logic             s_valid;
  pbs_pkg::in_req_t s_req;
  logic [5:0]       s_first;
  logic [RW-1:0]    s_even_row;
  logic [RW-1:0]    s_odd_row;

  logic          advance;
  logic          accept;
  logic [5:0]    a_first;
  logic [6:0]    a_first_ext;
  logic [6:0]    a_even_row7;
  logic [RW-1:0] a_even_row;
  logic [RW-1:0] a_odd_row;

  assign advance  = s_valid && (!out_valid || out_ready);
  assign in_ready = !clearing && (!s_valid || advance);
  assign accept   = in_valid && in_ready;

  // word accesses use word_index as the first word, fields the word of bit_position
  assign a_first     = in_req.kind[1] ? in_req.word_index : in_req.bit_position[9:4];
  assign a_first_ext = {1'b0, a_first};
  // even bank holds first or first+1, whichever is even
  assign a_even_row7 = (a_first_ext + {6'd0, a_first[0]}) >> 1;
  assign a_even_row  = RW'(a_even_row7[5:0]);
  assign a_odd_row   = RW'(a_first[5:1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_req      <= in_req;
      s_first    <= a_first;
      s_even_row <= a_even_row;
      s_odd_row  <= a_odd_row;
    end
  end

  // ---------------- banks ----------------
  logic                      e_we, o_we;
  logic [RW-1:0]             e_waddr, o_waddr;
  logic [pbs_pkg::WORD_W-1:0] e_wdata, o_wdata;
  logic [pbs_pkg::WORD_W-1:0] e_rdata, o_rdata;

  pbs_ram #(.WIDTH(pbs_pkg::WORD_W), .DEPTH(BANK_DEPTH)) u_even (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (accept),
    .raddr (a_even_row),
    .rdata (e_rdata)
  );

  pbs_ram #(.WIDTH(pbs_pkg::WORD_W), .DEPTH(BANK_DEPTH)) u_odd (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .re    (accept),
    .raddr (a_odd_row),
    .rdata (o_rdata)
  );

  // last write per bank; always the newest value at that row
  logic                       fe_valid, fo_valid;
  logic [RW-1:0]              fe_row, fo_row;
  logic [pbs_pkg::WORD_W-1:0] fe_data, fo_data;

  logic [pbs_pkg::WORD_W-1:0] even_word, odd_word;

  assign even_word = (fe_valid && fe_row == s_even_row) ? fe_data : e_rdata;
  assign odd_word  = (fo_valid && fo_row == s_odd_row)  ? fo_data : o_rdata;

  // ---------------- compute ----------------
  logic [pbs_pkg::WORD_W-1:0] w_first, w_second;
  logic [4:0]                 fw;
  logic [pbs_pkg::OFF_W-1:0]  off;
  logic [10:0]                last_bit;
  logic [6:0]                 last_word;
  logic                       straddle;
  logic [5:0]                 shift6;
  logic [4:0]                 shift;
  logic [pbs_pkg::PAIR_W-1:0] pair, mask, pmask, new_pair, shifted;
  logic                       field_err, word_err, err;
  logic                       we_first, we_second;
  logic [pbs_pkg::WORD_W-1:0] new_first, new_second;
  pbs_pkg::out_rsp_t          rsp;

  assign w_first  = s_first[0] ? odd_word  : even_word;
  assign w_second = s_first[0] ? even_word : odd_word;

  assign fw        = (s_req.field_width > 5'd16) ? 5'd16 : s_req.field_width;
  assign off       = s_req.bit_position[3:0];
  assign last_bit  = {1'b0, s_req.bit_position} + ((fw == 5'd0) ? 11'd0 : 11'(fw - 5'd1));
  assign last_word = last_bit[10:4];
  assign straddle  = ({1'b0, off} + fw) > 5'd16;

  // at least 1 and at most 31 for a nonzero width
  assign shift6 = 6'd32 - {1'b0, fw} - {2'b0, off};
  assign shift  = shift6[4:0];

  assign pair     = {w_first, straddle ? w_second : 16'd0};
  assign mask     = (32'd1 << fw) - 32'd1;
  assign pmask    = mask << shift;
  assign shifted  = pair >> shift;
  assign new_pair = (pair & ~pmask) | (({16'd0, s_req.write_value} & mask) << shift);

  assign field_err = (last_word >= words_in_use) || (int'(last_word) >= NUM_WORDS);
  assign word_err  = ({1'b0, s_req.word_index} >= words_in_use) ||
                     (int'(s_req.word_index) >= NUM_WORDS);

  always_comb begin
    rsp.read_data = '0;
    err           = 1'b0;
    we_first      = 1'b0;
    we_second     = 1'b0;
    new_first     = new_pair[31:16];
    new_second    = new_pair[15:0];
    unique case (s_req.kind)
      pbs_pkg::KIND_FIELD_READ: begin
        err = field_err;
        if (!field_err && fw != 5'd0) begin
          rsp.read_data = shifted[15:0] & mask[15:0];
        end
      end
      pbs_pkg::KIND_FIELD_WRITE: begin
        err       = field_err;
        we_first  = !field_err && fw != 5'd0;
        we_second = !field_err && fw != 5'd0 && straddle;
      end
      pbs_pkg::KIND_WORD_READ: begin
        err = word_err;
        if (!word_err) begin
          rsp.read_data = w_first;
        end
      end
      pbs_pkg::KIND_WORD_WRITE: begin
        err       = word_err;
        we_first  = !word_err;
        new_first = s_req.write_value;
      end
      default: begin
        err = 1'b0;
      end
    endcase
    rsp.range_error = err;
  end

  // ---------------- write-back ----------------
  logic st_e_we, st_o_we;
  logic [pbs_pkg::WORD_W-1:0] st_e_data, st_o_data;

  assign st_e_we   = advance && (s_first[0] ? we_second : we_first);
  assign st_o_we   = advance && (s_first[0] ? we_first  : we_second);
  assign st_e_data = s_first[0] ? new_second : new_first;
  assign st_o_data = s_first[0] ? new_first  : new_second;

  assign e_we    = clearing || st_e_we;
  assign o_we    = clearing || st_o_we;
  assign e_waddr = clearing ? clr_row : s_even_row;
  assign o_waddr = clearing ? clr_row : s_odd_row;
  assign e_wdata = clearing ? '0 : st_e_data;
  assign o_wdata = clearing ? '0 : st_o_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_valid <= 1'b0;
      fo_valid <= 1'b0;
    end else begin
      if (st_e_we) begin
        fe_valid <= 1'b1;
      end
      if (st_o_we) begin
        fo_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_e_we) begin
      fe_row  <= s_even_row;
      fe_data <= st_e_data;
    end
    if (st_o_we) begin
      fo_row  <= s_odd_row;
      fo_data <= st_o_data;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp <= rsp;
    end
  end

endmodule

/* rtl/core/pbs_checker.sv */
`include "packed_bitfield_store_assert.svh"

module pbs_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input pbs_pkg::out_rsp_t out_rsp
);

  // stalled result holds
  `PBS_ASSERT(a_out_hold,
              out_valid && !out_ready |=> out_valid && $stable(out_rsp),
              "result changed while stalled")

  // range errors never carry data
  `PBS_ASSERT(a_err_zero,
              out_valid && out_rsp.range_error |-> out_rsp.read_data == 16'd0,
              "range error with nonzero data")

  // out_valid is high once an accepted request has passed the request stage
  `PBS_ASSERT(a_latency, in_valid && in_ready |-> ##2 out_valid, "result missing after request")

  // clearing pass blocks requests right after reset
  `PBS_ASSERT_ALWAYS(a_reset_block, rst |=> !in_ready && !out_valid,
                     "request taken during clearing")

endmodule

bind packed_bitfield_store pbs_checker u_pbs_checker (.*);

/* bench/packed_bitfield_store_test.sv */
module packed_bitfield_store_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_WORDS = 64;
  // Slowest legal run is roughly 1750 requests x (long send gap + long
  // result stall + pipeline); the limit allows several times that.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Extra wait after the last response, covering the request stage and result register.
  localparam int SETTLE_CYCLES = 6;
  localparam int PRINT_LIMIT = 40;

  typedef struct {
    pbs_pkg::in_req_t  req;
    pbs_pkg::out_rsp_t rsp;
  } awaited_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  pbs_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pbs_pkg::out_rsp_t out_rsp;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Shadow copy of the store and of the words_in_use register.
  logic [15:0] shadow_words [NUM_WORDS];
  logic [6:0]  words_in_use_cfg;

  awaited_t    awaited_responses[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          no_idle = 1'b0;   // when set, neither side inserts gaps
  awaited_t    oldest;

  packed_bitfield_store #(.NUM_WORDS(NUM_WORDS)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp(out_rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Applies one request to the shadow store and returns the response the
  // block should give for it.
  function automatic pbs_pkg::out_rsp_t access_store(pbs_pkg::in_req_t r);
    pbs_pkg::out_rsp_t rsp;
    int unsigned lim, width, first, off, last_word, shift;
    logic [31:0] pair, mask;
    logic        straddle;
    rsp = '0;
    // register values above the store size clamp to the store size
    lim = (words_in_use_cfg > NUM_WORDS) ? NUM_WORDS : words_in_use_cfg;
    width = (r.field_width > 16) ? 16 : r.field_width;
    if (r.kind == pbs_pkg::KIND_FIELD_READ || r.kind == pbs_pkg::KIND_FIELD_WRITE) begin
      first = r.bit_position >> 4;
      off = r.bit_position[3:0];
      // zero width is still checked against the word holding the position
      last_word = (r.bit_position + ((width == 0) ? 0 : width - 1)) >> 4;
      straddle = (off + width) > 16;
      if (last_word >= lim) begin
        rsp.range_error = 1'b1;
      end else if (width != 0) begin
        mask = (32'd1 << width) - 32'd1;
        shift = 32 - width - off;
        pair = {shadow_words[first], straddle ? shadow_words[first + 1] : 16'h0000};
        if (r.kind == pbs_pkg::KIND_FIELD_READ) begin
          rsp.read_data = 16'((pair >> shift) & mask);
        end else begin
          pair = (pair & ~(mask << shift)) | ((32'(r.write_value) & mask) << shift);
          shadow_words[first] = pair[31:16];
          if (straddle) shadow_words[first + 1] = pair[15:0];
        end
      end
    end else if (r.word_index >= lim) begin
      rsp.range_error = 1'b1;
    end else if (r.kind == pbs_pkg::KIND_WORD_READ) begin
      rsp.read_data = shadow_words[r.word_index];
    end else begin
      shadow_words[r.word_index] = r.write_value;
    end
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input pbs_pkg::in_req_t r,
                                 input int got, input int want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t MISMATCH %s: kind %0d pos %0d width %0d idx %0d value %h got %h want %h",
               $realtime, what, r.kind, r.bit_position, r.field_width, r.word_index,
               r.write_value, got, want);
    mismatches++;
  endtask

  // Result checker: every accepted response against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_responses.size() == 0) begin
        report_mismatch("response with no request pending", '0, out_rsp, 0);
      end else begin
        oldest = awaited_responses.pop_front();
        if (out_rsp.read_data !== oldest.rsp.read_data)
          report_mismatch("read_data", oldest.req, out_rsp.read_data, oldest.rsp.read_data);
        if (out_rsp.range_error !== oldest.rsp.range_error)
          report_mismatch("range_error", oldest.req, out_rsp.range_error,
                          oldest.rsp.range_error);
      end
    end
  end

  // Result side back-pressure: random stalls between random ready bursts.
  initial begin : result_stalls
    int hold;
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Sends one request. Called on a clock edge; returns on the accepting edge
  // with valid still high so the next request can follow back to back.
  task automatic send_request(input pbs_pkg::in_req_t r);
    int gap;
    awaited_t entry;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!in_ready);
    entry.req = r;
    entry.rsp = access_store(r);
    awaited_responses.push_back(entry);
  endtask

  // Drops valid and waits for every outstanding response, plus the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of words_in_use: setup cycle, then access until pready.
  task automatic write_words_in_use(input logic [6:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {pbs_pkg::REG_WORDS_IN_USE, 2'b00};
    pwdata <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    words_in_use_cfg = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic pbs_pkg::in_req_t make_req(input logic [1:0] kind, input int pos,
                                                input int width, input int idx,
                                                input int value);
    pbs_pkg::in_req_t r;
    r.kind = kind;
    r.bit_position = 10'(pos);
    r.field_width = 5'(width);
    r.word_index = 6'(idx);
    r.write_value = 16'(value);
    return r;
  endfunction

  // Random request. Most addresses land inside the first span words so the
  // store actually fills and gets read back; the rest cover the full field.
  function automatic pbs_pkg::in_req_t random_req(input int span);
    pbs_pkg::in_req_t r;
    int roll;
    r.kind = 2'($urandom_range(0, 3));
    if (span > 0 && $urandom_range(0, 9) < 7) begin
      r.bit_position = 10'($urandom_range(0, span * 16 - 1));
      r.word_index = 6'($urandom_range(0, span - 1));
    end else begin
      r.bit_position = 10'($urandom_range(0, 1023));
      r.word_index = 6'($urandom_range(0, 63));
    end
    roll = $urandom_range(0, 99);
    if (roll < 80) r.field_width = 5'($urandom_range(1, 16));
    else if (roll < 88) r.field_width = 5'd0;
    else r.field_width = 5'($urandom_range(17, 31));
    r.write_value = 16'($urandom);
    return r;
  endfunction

  // ---- directed tests (store full size after reset) ----

  task automatic test_word_access();
    send_request(make_req(pbs_pkg::KIND_WORD_READ, 0, 0, 5, 0));     // cleared after reset
    send_request(make_req(pbs_pkg::KIND_WORD_WRITE, 0, 0, 0, 16'hFFFF));
    send_request(make_req(pbs_pkg::KIND_WORD_WRITE, 0, 0, 63, 16'hA5A5));
    send_request(make_req(pbs_pkg::KIND_WORD_READ, 0, 0, 0, 0));
    send_request(make_req(pbs_pkg::KIND_WORD_READ, 0, 0, 63, 0));
  endtask

  task automatic test_field_bounds();
    send_request(make_req(pbs_pkg::KIND_FIELD_READ, 0, 1, 0, 0));    // MSB of word 0
    send_request(make_req(pbs_pkg::KIND_FIELD_WRITE, 16, 16, 0, 16'h1234));
    send_request(make_req(pbs_pkg::KIND_FIELD_READ, 16, 16, 0, 0));
    send_request(make_req(pbs_pkg::KIND_FIELD_READ, 1023, 1, 0, 0)); // very last bit
    send_request(make_req(pbs_pkg::KIND_FIELD_READ, 1023, 2, 0, 0)); // runs off the end
  endtask

  task automatic test_straddles();
    send_request(make_req(pbs_pkg::KIND_FIELD_WRITE, 14, 4, 0, 16'h000A));
    send_request(make_req(pbs_pkg::KIND_FIELD_READ, 12, 8, 0, 0));
    send_request(make_req(pbs_pkg::KIND_FIELD_WRITE, 47, 16, 0, 16'hBEEF)); // widest straddle
    send_request(make_req(pbs_pkg::KIND_FIELD_READ, 47, 16, 0, 0));
  endtask

  task automatic test_width_corners();
    send_request(make_req(pbs_pkg::KIND_FIELD_READ, 5, 0, 0, 0));    // zero width
    send_request(make_req(pbs_pkg::KIND_FIELD_WRITE, 5, 0, 0, 16'hFFFF));
    send_request(make_req(pbs_pkg::KIND_FIELD_WRITE, 100, 31, 0, 16'hFFFF)); // clamps to 16
    send_request(make_req(pbs_pkg::KIND_FIELD_READ, 100, 17, 0, 0));
    send_request(make_req(pbs_pkg::KIND_FIELD_READ, 1020, 0, 0, 0)); // zero width, last word
  endtask

  task automatic test_words_in_use_limits();
    settle();
    write_words_in_use(7'd1);
    send_request(make_req(pbs_pkg::KIND_FIELD_READ, 15, 2, 0, 0));   // straddles into word 1
    send_request(make_req(pbs_pkg::KIND_WORD_WRITE, 0, 0, 1, 16'h5555)); // dropped
    send_request(make_req(pbs_pkg::KIND_WORD_READ, 0, 0, 0, 0));
    settle();
    write_words_in_use(7'd0);                                  // everything errors
    send_request(make_req(pbs_pkg::KIND_FIELD_READ, 0, 0, 0, 0));
    send_request(make_req(pbs_pkg::KIND_WORD_READ, 0, 0, 0, 0));
    settle();
    write_words_in_use(7'd127);                                // clamps to the store
    send_request(make_req(pbs_pkg::KIND_WORD_READ, 0, 0, 63, 0));
  endtask

  // ---- random tests ----

  task automatic run_random_phase(input logic [6:0] wiu, input int count, input int hot_words);
    int span;
    settle();
    write_words_in_use(wiu);
    span = (hot_words > 0) ? hot_words : ((wiu > NUM_WORDS) ? NUM_WORDS : wiu);
    repeat (count) send_request(random_req(span));
  endtask

  task automatic test_random_traffic();
    run_random_phase(7'd64, 400, 0);
    run_random_phase(7'd1, 100, 0);
    run_random_phase(7'd2, 150, 0);
    run_random_phase(7'd0, 50, 0);
    run_random_phase(7'd127, 200, 0);
    run_random_phase(7'($urandom_range(3, 63)), 300, 0);
    run_random_phase(7'($urandom_range(65, 126)), 100, 0);
  endtask

  // Back-to-back read-modify-writes on a handful of words, no gaps on either
  // side, to hammer the bank bypass paths; then a random phase with gaps.
  task automatic test_back_to_back();
    settle();
    no_idle = 1'b1;
    run_random_phase(7'd64, 300, 4);
    settle();
    no_idle = 1'b0;
    run_random_phase(7'd64, 150, 0);
  endtask

  initial begin : main
    foreach (shadow_words[i]) shadow_words[i] = '0;
    words_in_use_cfg = 7'd64;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_word_access();
    test_field_bounds();
    test_straddles();
    test_width_corners();
    test_words_in_use_limits();
    test_random_traffic();
    test_back_to_back();
    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/pbs_pkg.sv
rtl/core/pbs_ram.sv
rtl/core/packed_bitfield_store.sv
rtl/core/pbs_checker.sv
bench/packed_bitfield_store_test.sv
